// ===== hdl/rcz_pkg.sv =====
package rcz_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int TAP_BITS_DEF  = 8;
  localparam int CHAN_MAX      = 255;

  // output queue behind the filter pipeline
  localparam int FIFO_DEPTH = 8;

  // configuration port
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TAPS_TOP     = 3'd2;
  localparam logic [2:0] REG_TAPS_MIDDLE  = 3'd3;
  localparam logic [2:0] REG_TAPS_BOTTOM  = 3'd4;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
  localparam int          TAPS_MIDDLE_RST  = 256;

  // item kinds on the input channel
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef pix_t [2:0][2:0] window_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bottom_ok;
    logic left_ok;
    logic right_ok;
  } win_meta_t;

  typedef struct packed {
    logic last;
    pix_t pix;
  } out_item_t;

  function automatic int tap_reg_bits(int tap_bits);
    return (3 * tap_bits > 32) ? 32 : 3 * tap_bits;
  endfunction

endpackage

// ===== hdl/rgb_conv3x3_zero_pad.sv =====
// results pass the line store, window, product and row-sum registers into the output queue
// one item per cycle while in_tready is high; line stores read once and write once per cycle
// in_tready falls only when the 8-entry output queue and the pipeline hold 8 pending items
// reset: synchronous active-low rst_n clears counters, window, queue and registers to defaults
// the line stores are not cleared
module rgb_conv3x3_zero_pad import rcz_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int TAP_BITS  = TAP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // blue_in, green_in, red_in from the top byte down
  input  logic              in_tuser,   // operation

  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // blue_out, green_out, red_out from the top byte down
  output logic              out_tlast,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int TRW = tap_reg_bits(TAP_BITS);
  localparam int FAW = $clog2(FIFO_DEPTH);

  // configuration registers
  logic [10:0]    frame_width_r;
  logic [12:0]    frame_height_r;
  logic [TRW-1:0] taps_top_r;
  logic [TRW-1:0] taps_middle_r;
  logic [TRW-1:0] taps_bottom_r;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;

  logic [WW-1:0]  eff_w;
  logic [12:0]    eff_h;

  // position counters
  logic [CW-1:0]  in_col_r,  in_col_nxt;
  logic [1:0]     in_row_r,  in_row_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic [12:0]    out_row_r, out_row_nxt;

  logic           in_acc;
  logic [WW-1:0]  in_col_inc;
  logic           in_wrap;
  logic [WW-1:0]  out_col_inc;
  logic [13:0]    out_row_inc;
  win_meta_t      acc_meta;
  pix_t           acc_px;

  win_meta_t      b_meta_r;
  logic           col_vld;
  pix_t           col_upper;
  pix_t           col_lower;
  pix_t           col_px;

  window_t        win_r;
  win_meta_t      c_meta_r;
  logic           c_vld_r;

  logic           mac_res_vld;
  pix_t           mac_res_pix;
  logic           mac_res_last;

  // output queue
  out_item_t      fifo_mem [FIFO_DEPTH];
  logic [FAW-1:0] fifo_wr_ptr_r;
  logic [FAW-1:0] fifo_rd_ptr_r;
  logic [FAW:0]   fifo_cnt_r;
  logic [FAW:0]   occ_r;
  logic           out_pop;
  logic           drop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      taps_top_r     <= '0;
      taps_middle_r  <= TRW'(TAPS_MIDDLE_RST);
      taps_bottom_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[10:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[12:0];
        REG_TAPS_TOP:     taps_top_r     <= cfg_pwdata[TRW-1:0];
        REG_TAPS_MIDDLE:  taps_middle_r  <= cfg_pwdata[TRW-1:0];
        REG_TAPS_BOTTOM:  taps_bottom_r  <= cfg_pwdata[TRW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  cfg_prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(frame_height_r);
      REG_TAPS_TOP:     cfg_prdata = 32'(taps_top_r);
      REG_TAPS_MIDDLE:  cfg_prdata = 32'(taps_middle_r);
      REG_TAPS_BOTTOM:  cfg_prdata = 32'(taps_bottom_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_r);
    end
    eff_h = (frame_height_r == '0) ? 13'd1 : frame_height_r;
  end

  assign in_acc = in_tvalid && in_tready;
  assign acc_px = (in_tuser == OP_DRAIN) ? pix_t'('0) : pix_t'(in_tdata);

  // window position and padding flags of the item at the input
  always_comb begin
    in_col_inc  = {1'b0, in_col_r} + WW'(1);
    in_wrap     = in_col_inc >= eff_w;
    out_col_inc = {1'b0, out_col_r} + WW'(1);
    out_row_inc = {1'b0, out_row_r} + 14'd1;

    acc_meta.emit      = (in_row_r >= 2'd2) || (in_row_r == 2'd1 && in_col_r != '0);
    acc_meta.top_ok    = out_row_r != '0;
    acc_meta.bottom_ok = out_row_inc < {1'b0, eff_h};
    acc_meta.left_ok   = out_col_r != '0;
    acc_meta.right_ok  = out_col_inc < eff_w;
    acc_meta.last      = !acc_meta.right_ok && !acc_meta.bottom_ok;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (in_acc) begin
      in_col_nxt = in_wrap ? '0 : in_col_inc[CW-1:0];
      if (in_wrap && in_row_r != 2'd2) begin
        in_row_nxt = in_row_r + 2'd1;
      end
      if (acc_meta.emit) begin
        if (acc_meta.right_ok) begin
          out_col_nxt = out_col_inc[CW-1:0];
        end else begin
          out_col_nxt = '0;
          out_row_nxt = out_row_inc[12:0];
        end
        if (acc_meta.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_meta_r <= acc_meta;
    end
  end

  rcz_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr   (in_col_r),
    .px_in     (acc_px),
    .col_vld   (col_vld),
    .col_upper (col_upper),
    .col_lower (col_lower),
    .col_px    (col_px)
  );

  // 3x3 window shifts left by one column per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= col_vld && b_meta_r.emit;
      if (col_vld) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= col_upper;
        win_r[1][2] <= col_lower;
        win_r[2][2] <= col_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_vld) begin
      c_meta_r <= b_meta_r;
    end
  end

  rcz_mac #(
    .TAP_BITS (TAP_BITS)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .win_vld     (c_vld_r),
    .win         (win_r),
    .meta        (c_meta_r),
    .taps_top    (taps_top_r),
    .taps_middle (taps_middle_r),
    .taps_bottom (taps_bottom_r),
    .res_vld     (mac_res_vld),
    .res_pix     (mac_res_pix),
    .res_last    (mac_res_last)
  );

  // credit count: items accepted and not yet dropped or transferred out
  assign drop       = col_vld && !b_meta_r.emit;
  assign out_tvalid = fifo_cnt_r != '0;
  assign out_pop    = out_tvalid && out_tready;
  assign in_tready  = occ_r < (FAW+1)'(FIFO_DEPTH);
  assign out_tdata  = fifo_mem[fifo_rd_ptr_r].pix;
  assign out_tlast  = fifo_mem[fifo_rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (mac_res_vld) begin
      fifo_mem[fifo_wr_ptr_r] <= '{last: mac_res_last, pix: mac_res_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wr_ptr_r <= '0;
      fifo_rd_ptr_r <= '0;
      fifo_cnt_r    <= '0;
      occ_r         <= '0;
    end else begin
      if (mac_res_vld) begin
        fifo_wr_ptr_r <= fifo_wr_ptr_r + FAW'(1);
      end
      if (out_pop) begin
        fifo_rd_ptr_r <= fifo_rd_ptr_r + FAW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + (FAW+1)'(mac_res_vld) - (FAW+1)'(out_pop);
      occ_r      <= occ_r + (FAW+1)'(in_acc) - (FAW+1)'(drop) - (FAW+1)'(out_pop);
    end
  end

  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    mac_res_vld |-> (fifo_cnt_r < (FAW+1)'(FIFO_DEPTH)))
    else $error("result written into a full output queue");

  a_credit_cover: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r >= fifo_cnt_r)
    else $error("credit count below output queue fill");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && acc_meta.emit && acc_meta.last) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("counters not restarted after final pixel of frame");

endmodule

// ===== hdl/rcz_line_buf.sv =====
module rcz_line_buf import rcz_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  pix_t                         px_in,
  output logic                         col_vld,
  output pix_t                         col_upper,
  output pix_t                         col_lower,
  output pix_t                         col_px
);

  localparam int CW = $clog2(MAX_WIDTH);

  pix_t upper_mem [MAX_WIDTH];
  pix_t lower_mem [MAX_WIDTH];

  logic          b_vld_r;
  logic [CW-1:0] b_addr_r;
  pix_t          b_px_r;
  pix_t          up_q_r;
  pix_t          lo_q_r;

  logic          wr_vld_r;
  logic [CW-1:0] wr_addr_r;
  pix_t          wr_up_r;
  pix_t          wr_lo_r;

  logic fwd;
  pix_t up_eff;
  pix_t lo_eff;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q_r <= upper_mem[rd_addr];
      lo_q_r <= lower_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      upper_mem[b_addr_r] <= lo_eff;
      lower_mem[b_addr_r] <= b_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r  <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      b_vld_r  <= rd_en;
      wr_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      b_addr_r <= rd_addr;
      b_px_r   <= px_in;
    end
    wr_addr_r <= b_addr_r;
    wr_up_r   <= lo_eff;
    wr_lo_r   <= b_px_r;
  end

  // same entry read while the previous write to it was in flight
  assign fwd    = b_vld_r && wr_vld_r && (wr_addr_r == b_addr_r);
  assign up_eff = fwd ? wr_up_r : up_q_r;
  assign lo_eff = fwd ? wr_lo_r : lo_q_r;

  assign col_vld   = b_vld_r;
  assign col_upper = up_eff;
  assign col_lower = lo_eff;
  assign col_px    = b_px_r;

endmodule

// ===== hdl/rcz_mac.sv =====
module rcz_mac import rcz_pkg::*; #(
  parameter int TAP_BITS = TAP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                win_vld,
  input  window_t                             win,
  input  win_meta_t                           meta,
  input  logic [tap_reg_bits(TAP_BITS)-1:0]   taps_top,
  input  logic [tap_reg_bits(TAP_BITS)-1:0]   taps_middle,
  input  logic [tap_reg_bits(TAP_BITS)-1:0]   taps_bottom,
  output logic                                res_vld,
  output pix_t                                res_pix,
  output logic                                res_last
);

  localparam int TW = 3 * TAP_BITS;
  localparam int PW = TAP_BITS + 9;
  localparam int RW = PW + 2;
  localparam int SW = PW + 4;

  logic [2:0][TW-1:0]          tap_ext;
  logic signed [TAP_BITS-1:0]  tap    [3][3];
  logic                        ok     [3][3];
  logic [2:0]                  row_ok;
  logic [2:0]                  col_ok;
  logic signed [8:0]           pxs    [3][3][3];
  logic signed [PW-1:0]        prod   [3][3][3];

  logic                        p_vld_r;
  logic                        p_last_r;
  logic signed [PW-1:0]        prod_r [3][3][3];
  logic                        s_vld_r;
  logic                        s_last_r;
  logic signed [RW-1:0]        rsum_r [3][3];
  logic signed [SW-1:0]        tot    [3];

  assign tap_ext[0] = TW'(taps_top);
  assign tap_ext[1] = TW'(taps_middle);
  assign tap_ext[2] = TW'(taps_bottom);

  assign row_ok = {meta.bottom_ok, 1'b1, meta.top_ok};
  assign col_ok = {meta.right_ok, 1'b1, meta.left_ok};

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign tap[r][c] = signed'(tap_ext[r][c*TAP_BITS +: TAP_BITS]);
      assign ok[r][c]  = row_ok[r] && col_ok[c];
      for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        assign pxs[ch][r][c]  = signed'({1'b0, win[r][c][ch*8 +: 8]});
        assign prod[ch][r][c] = pxs[ch][r][c] * tap[r][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      p_vld_r <= win_vld;
      s_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p_last_r <= meta.last;
    s_last_r <= p_last_r;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[ch][r][c] <= ok[r][c] ? prod[ch][r][c] : {PW{1'b0}};
        end
        rsum_r[ch][r] <= prod_r[ch][r][0] + prod_r[ch][r][1] + prod_r[ch][r][2];
      end
    end
  end

  // total and clamp to 0..255
  always_comb begin
    res_pix = '0;
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = rsum_r[ch][0] + rsum_r[ch][1] + rsum_r[ch][2];
      if (tot[ch] < 0) begin
        res_pix[ch*8 +: 8] = 8'd0;
      end else if (tot[ch] > CHAN_MAX) begin
        res_pix[ch*8 +: 8] = 8'(CHAN_MAX);
      end else begin
        res_pix[ch*8 +: 8] = tot[ch][7:0];
      end
    end
  end

  assign res_vld  = s_vld_r;
  assign res_last = s_last_r;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rcz_pkg::*;

  localparam int          LIMIT_CYCLES  = 1_000_000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          REPORT_MAX    = 10;
  localparam int          RANDOM_ITEMS  = 420;
  localparam int          SETTLE_CYCLES = 12;
  localparam int unsigned ROW_CAP       = 32'h000F_FFFF;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [23:0] value;
    logic        op;
    pix_t        px;
    logic        typed;
    pix_t        want;
    logic        want_last;
  } dir_row_t;

  // pixels are written blue, green, red from the top byte down
  localparam dir_row_t DIRECTED [38] = '{
    '{ROW_WRITE, REG_FRAME_WIDTH,  24'd1,      OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 24'd1,      OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'ha500ff, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h5a5a5a, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'ha500ff, 1'b1},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'h5aff00, 1'b0, 24'h0,      1'b0},
    // pixel past the end of the frame acts as a drain
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'hffffff, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'h5aff00, 1'b1},
    // zero sizes act as one
    '{ROW_WRITE, REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 24'd0,      OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'h563412, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'hffffff, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'h563412, 1'b1},
    // largest positive taps saturate high
    '{ROW_WRITE, REG_TAPS_TOP,     24'h7f7f7f, OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_TAPS_MIDDLE,  24'h7f7f7f, OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_TAPS_BOTTOM,  24'h7f7f7f, OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_FRAME_WIDTH,  24'd3,      OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 24'd2,      OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'hffffff, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'hffffff, 1'b0, 24'h0,      1'b0},
    // drain inside the frame is a black pixel
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'hffffff, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'hffffff, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'hffffff, 1'b1, 24'hffffff, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'hffffff, 1'b1, 24'hffffff, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'hffffff, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'hffffff, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'hffffff, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'hffffff, 1'b1},
    // most negative taps clamp to zero
    '{ROW_WRITE, REG_TAPS_TOP,     24'h808080, OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_TAPS_MIDDLE,  24'h808080, OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_TAPS_BOTTOM,  24'h808080, OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_FRAME_WIDTH,  24'd2,      OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 24'd1,      OP_PIXEL, 24'h0,      1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'h7f80ff, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_PIXEL, 24'hffffff, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b0, 24'h0,      1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'h000000, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  24'd0,      OP_DRAIN, 24'h000000, 1'b1, 24'h000000, 1'b1}
  };

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata    = '0;
  logic              in_tuser    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [23:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  rgb_conv3x3_zero_pad dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter state mirrored in the testbench
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] tap_row [3];
  pix_t        line_up [MAX_WIDTH_DEF];
  pix_t        line_lo [MAX_WIDTH_DEF];
  pix_t        win [3][3];
  int unsigned col_in, row_in, col_out, row_out;

  out_item_t   pending_pix [$];
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_ticket = 0;
  int          bad_count   = 0;
  int          items_sent  = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int stall_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [23:0] rand_taps();
    logic [23:0] t;
    int          c;
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    for (c = 0; c < 3; c++) t[8*c +: 8] = 8'(int'($urandom_range(0, 6)) - 3);
    return t;
  endfunction

  // shifts one item through line stores and window, returns 1 when a pixel comes out
  function automatic bit filter_step(input logic op, input pix_t px_in, output out_item_t res);
    int unsigned w, h, col;
    bit          emit;
    pix_t        px;
    bit          col_ok [3];
    bit          row_ok [3];
    int          acc, tv, pv, r, c, k;
    logic [7:0]  chan [3];
    w    = active_width();
    h    = active_height();
    col  = (col_in < MAX_WIDTH_DEF) ? col_in : MAX_WIDTH_DEF - 1;
    emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
    px   = (op == OP_PIXEL) ? px_in : '0;
    res  = '0;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2]    = line_up[col];
    win[1][2]    = line_lo[col];
    win[2][2]    = px;
    line_up[col] = line_lo[col];
    line_lo[col] = px;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      if (row_in < ROW_CAP) row_in++;
    end
    if (!emit) return 0;
    col_ok[0] = col_out > 0;
    col_ok[1] = 1'b1;
    col_ok[2] = col_out + 1 < w;
    row_ok[0] = row_out > 0;
    row_ok[1] = 1'b1;
    row_ok[2] = row_out + 1 < h;
    for (k = 0; k < 3; k++) begin
      acc = 0;
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            pv  = win[r][c][8*k +: 8];
            tv  = $signed(tap_row[r][8*c +: 8]);
            acc += pv * tv;
          end
        end
      end
      if (acc < 0) acc = 0;
      if (acc > CHAN_MAX) acc = CHAN_MAX;
      chan[k] = 8'(acc);
    end
    res.pix.red   = chan[0];
    res.pix.green = chan[1];
    res.pix.blue  = chan[2];
    res.last      = (col_out + 1 >= w) && (row_out + 1 >= h);
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      if (row_out < ROW_CAP) row_out++;
    end
    if (res.last) begin
      col_in  = 0;
      row_in  = 0;
      col_out = 0;
      row_out = 0;
    end
    return 1;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    in_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  width_reg  = val[10:0];
      REG_FRAME_HEIGHT: height_reg = val[12:0];
      REG_TAPS_TOP:     tap_row[0] = val;
      REG_TAPS_MIDDLE:  tap_row[1] = val;
      REG_TAPS_BOTTOM:  tap_row[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    write_reg(REG_FRAME_WIDTH, 24'(w));
    write_reg(REG_FRAME_HEIGHT, 24'(h));
  endtask

  task automatic set_taps();
    write_reg(REG_TAPS_TOP, rand_taps());
    write_reg(REG_TAPS_MIDDLE, rand_taps());
    write_reg(REG_TAPS_BOTTOM, rand_taps());
  endtask

  task automatic send_item(input logic op, input pix_t px, input logic typed,
                           input pix_t want, input logic want_last, output bit frame_end);
    int        gap;
    bit        got;
    out_item_t res;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? stall_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    got = filter_step(op, px, res);
    if (got && typed) begin
      res.pix  = want;
      res.last = want_last;
    end
    if (got) pending_pix.push_back(res);
    frame_end = got && res.last;
  endtask

  // feeds one frame plus its drain; cut_at >= 0 narrows the frame after that many items
  task automatic run_frame(input int cut_at, input logic [10:0] cut_width);
    bit   done;
    int   n, k;
    logic op;
    pix_t px;
    done = 1'b0;
    n    = 0;
    while (!done) begin
      if (n == cut_at) write_reg(REG_FRAME_WIDTH, 24'(cut_width));
      if (row_in < active_height()) op = ($urandom_range(0, 99) < 4) ? OP_DRAIN : OP_PIXEL;
      else op = ($urandom_range(0, 99) < 15) ? OP_PIXEL : OP_DRAIN;
      px = pix_t'($urandom);
      for (k = 0; k < 3; k++) begin
        case ($urandom_range(0, 9))
          0: px[8*k +: 8] = 8'h00;
          1: px[8*k +: 8] = 8'hff;
          default: ;
        endcase
      end
      send_item(op, px, 1'b0, '0, 1'b0, done);
      n++;
    end
  endtask

  // output side: checking and back-pressure
  int hold_served = 0;
  int hold_left   = 0;
  int rx_gap      = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pix.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_MAX)
          $display("unexpected transfer: data %h last %b", out_tdata, out_tlast);
      end else begin
        want = pending_pix.pop_front();
        if (out_tdata[7:0] !== want.pix.red || out_tdata[15:8] !== want.pix.green ||
            out_tdata[23:16] !== want.pix.blue || out_tlast !== want.last) begin
          bad_count++;
          if (bad_count <= REPORT_MAX)
            $display("mismatch: want r %h g %h b %h last %b, got r %h g %h b %h last %b",
                     want.pix.red, want.pix.green, want.pix.blue, want.last,
                     out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast);
        end
      end
    end
    if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_gap = stall_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  int idle_levels [4] = '{0, 10, 30, 60};

  initial begin
    bit done;
    int frames, start;
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    tap_row[0] = '0;
    tap_row[1] = 24'(TAPS_MIDDLE_RST);
    tap_row[2] = '0;
    foreach (line_up[i]) begin
      line_up[i] = '0;
      line_lo[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
      else send_item(DIRECTED[i].op, DIRECTED[i].px, DIRECTED[i].typed,
                     DIRECTED[i].want, DIRECTED[i].want_last, done);
    end

    // frame narrowed part way through
    set_taps();
    set_size(8, 6);
    run_frame(8 * 3 + 2, 11'd5);

    frames = 0;
    start  = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      tx_idle_pct = (frames == 0) ? 0 : idle_levels[$urandom_range(0, 3)];
      rx_idle_pct = idle_levels[$urandom_range(0, 3)];
      if (frames == 0) set_size(12, 6);
      else if ($urandom_range(0, 4) == 0) set_size($urandom_range(1, 40), $urandom_range(1, 12));
      else set_size($urandom_range(1, 10), $urandom_range(1, 6));
      if (frames == 0 || $urandom_range(0, 1) == 0) set_taps();
      if (frames == 0 || $urandom_range(0, 7) == 0) hold_ticket++;
      run_frame(-1, '0);
      frames++;
    end

    // size extremes: width above the limit acts as the limit, narrowed once results flow
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    set_taps();
    set_size(2047, 1);
    run_frame(MAX_WIDTH_DEF + 6, 11'd8);
    set_taps();
    set_size(1, 150);
    run_frame(-1, '0);

    in_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_count == 0 && pending_pix.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
